### rtl/packet_slot_pool_assert.svh
// assertion macros shared by the packet slot pool rtl
`ifndef PACKET_SLOT_POOL_ASSERT_SVH
`define PACKET_SLOT_POOL_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/psp_pkg.sv
// types and constants for the packet slot pool
`default_nettype none

package psp_pkg;

  localparam int SLOT_COUNT        = 16;
  localparam int SLOT_IW           = $clog2(SLOT_COUNT);
  localparam int MAX_PACKET_LENGTH = 256;

  localparam int OPCODE_W = 3;
  localparam int INDEX_W  = 4;
  localparam int LENGTH_W = 9;
  localparam int REPEAT_W = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;

  // operation codes
  localparam logic [OPCODE_W-1:0] OP_REINIT     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ALLOCATE   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_QUEUE      = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_NEXT_PEND  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_COUNT_SEND = 3'd4;

  // response codes
  localparam logic [STATUS_W-1:0] RSP_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] RSP_NONE    = 2'd1;
  localparam logic [STATUS_W-1:0] RSP_BAD_IDX = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // per-slot state
  typedef enum logic [1:0] {
    SL_FREE    = 2'd0,
    SL_HANDED  = 2'd1,
    SL_PENDING = 2'd2,
    SL_SENT    = 2'd3
  } slot_st_t;

  // sequencer state
  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_QUEUE,
    S_COUNT,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

### rtl/packet_slot_pool.sv
// packet slot pool: sequencer walking the slot table through one shared slot port
// After acceptance the sequencer runs its work states, then loads the output register in S_RESULT;
// a bad index or unknown opcode goes straight to S_RESULT, queue and count_send go through S_QUEUE
// or S_COUNT, allocate scans, next_pending scans then counts, and reinit clears (one slot cleared per cycle).
// One transaction at a time: in_stall is high until the result is loaded into the output register.
// Reset (synchronous, rst_n low) frees every slot, zeroes send counts, sets targets to one.
`default_nettype none

module packet_slot_pool
  import psp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [OPCODE_W-1:0] in_opcode,
  input  wire logic [INDEX_W-1:0]  in_slot_index,
  input  wire logic [LENGTH_W-1:0] in_packet_length,
  input  wire logic [REPEAT_W-1:0] in_send_repeat,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [INDEX_W-1:0]       out_chosen_slot,
  output logic [LENGTH_W-1:0]      out_chosen_length,
  output logic                     out_became_sent
);

`include "packet_slot_pool_assert.svh"

  // slot table
  slot_st_t             slot_st_r   [SLOT_COUNT];
  logic [COUNT_W-1:0]   sends_done_r[SLOT_COUNT];
  logic [REPEAT_W-1:0]  sends_want_r[SLOT_COUNT];
  logic [LENGTH_W-1:0]  slot_len_r  [SLOT_COUNT];

  // sequencer and command registers
  state_t               state_r, state_nxt;
  logic [SLOT_IW-1:0]   ptr_r, ptr_nxt;
  logic [OPCODE_W-1:0]  op_r, op_nxt;
  logic [LENGTH_W-1:0]  len_r, len_nxt;
  logic [REPEAT_W-1:0]  rep_r, rep_nxt;

  // result being built
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [INDEX_W-1:0]   res_slot_r, res_slot_nxt;
  logic [LENGTH_W-1:0]  res_len_r, res_len_nxt;
  logic                 res_sent_r, res_sent_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r;
  logic [INDEX_W-1:0]   out_slot_r;
  logic [LENGTH_W-1:0]  out_len_r;
  logic                 out_sent_r;
  logic                 out_load;

  // slot port write controls
  logic                 wr_st_en, wr_done_en, wr_want_en, wr_len_en;
  slot_st_t             wr_st_val;
  logic [COUNT_W-1:0]   wr_done_val;
  logic [REPEAT_W-1:0]  wr_want_val;

  // shared slot read at the pointer
  slot_st_t             rd_st;
  logic [COUNT_W-1:0]   rd_done;
  logic [REPEAT_W-1:0]  rd_want;
  logic [COUNT_W-1:0]   done_inc;
  logic                 cnt_hit;
  slot_st_t             scan_target;
  logic                 ptr_last;
  logic                 in_accept;
  logic                 bad_idx;
  logic [LENGTH_W-1:0]  len_sat;

  assign rd_st    = slot_st_r[ptr_r];
  assign rd_done  = sends_done_r[ptr_r];
  assign rd_want  = sends_want_r[ptr_r];
  assign ptr_last = (ptr_r == SLOT_IW'(SLOT_COUNT - 1));

  // shared send counter: saturating increment and target compare
  assign done_inc = (rd_done == COUNT_MAX) ? rd_done : rd_done + 1'b1;
  assign cnt_hit  = ({1'b0, done_inc} >= {1'b0, rd_want});

  assign scan_target = (op_r == OP_ALLOCATE) ? SL_FREE : SL_PENDING;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign bad_idx   = (int'(in_slot_index) >= SLOT_COUNT);
  assign len_sat   = (int'(in_packet_length) > MAX_PACKET_LENGTH) ?
                     LENGTH_W'(MAX_PACKET_LENGTH) : in_packet_length;

  assign out_load = (state_r == S_RESULT) && (!out_valid_r || !out_stall);

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // command, pointer and result registers
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    op_r         <= op_nxt;
    len_r        <= len_nxt;
    rep_r        <= rep_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_len_r    <= res_len_nxt;
    res_sent_r   <= res_sent_nxt;
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_len_r    <= res_len_r;
      out_sent_r   <= res_sent_r;
    end
  end

  // next state and slot port controls
  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    op_nxt         = op_r;
    len_nxt        = len_r;
    rep_nxt        = rep_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_len_nxt    = res_len_r;
    res_sent_nxt   = res_sent_r;
    out_valid_nxt  = out_valid_r;
    wr_st_en       = 1'b0;
    wr_st_val      = SL_FREE;
    wr_done_en     = 1'b0;
    wr_done_val    = '0;
    wr_want_en     = 1'b0;
    wr_want_val    = '0;
    wr_len_en      = 1'b0;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt         = in_opcode;
          len_nxt        = len_sat;
          rep_nxt        = in_send_repeat;
          res_status_nxt = RSP_OK;
          res_slot_nxt   = '0;
          res_len_nxt    = '0;
          res_sent_nxt   = 1'b0;
          ptr_nxt        = '0;
          unique case (in_opcode)
            OP_REINIT:                 state_nxt = S_CLEAR;
            OP_ALLOCATE, OP_NEXT_PEND: state_nxt = S_SCAN;
            OP_QUEUE, OP_COUNT_SEND: begin
              if (bad_idx) begin
                res_status_nxt = RSP_BAD_IDX;
                state_nxt      = S_RESULT;
              end else begin
                ptr_nxt   = SLOT_IW'(in_slot_index);
                state_nxt = (in_opcode == OP_QUEUE) ? S_QUEUE : S_COUNT;
              end
            end
            default:                   state_nxt = S_RESULT;
          endcase
        end
      end

      // clearing sweep, one slot a cycle
      S_CLEAR: begin
        wr_st_en    = 1'b1;
        wr_st_val   = SL_FREE;
        wr_done_en  = 1'b1;
        wr_done_val = '0;
        wr_want_en  = 1'b1;
        wr_want_val = REPEAT_W'(1);
        ptr_nxt     = ptr_r + 1'b1;
        if (ptr_last) begin
          state_nxt = S_RESULT;
        end
      end

      // lowest-first search for a free or pending slot
      S_SCAN: begin
        if (rd_st == scan_target) begin
          res_slot_nxt = INDEX_W'(ptr_r);
          if (op_r == OP_ALLOCATE) begin
            wr_st_en  = 1'b1;
            wr_st_val = SL_HANDED;
            state_nxt = S_RESULT;
          end else begin
            res_len_nxt = slot_len_r[ptr_r];
            state_nxt   = S_COUNT;
          end
        end else if (ptr_last) begin
          res_status_nxt = RSP_NONE;
          state_nxt      = S_RESULT;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      S_QUEUE: begin
        wr_st_en    = 1'b1;
        wr_st_val   = SL_PENDING;
        wr_want_en  = 1'b1;
        wr_want_val = rep_r;
        wr_len_en   = 1'b1;
        state_nxt   = S_RESULT;
      end

      // one send on the slot at the pointer
      S_COUNT: begin
        wr_done_en   = 1'b1;
        wr_done_val  = done_inc;
        res_slot_nxt = INDEX_W'(ptr_r);
        if (cnt_hit) begin
          wr_st_en     = 1'b1;
          wr_st_val    = SL_SENT;
          res_sent_nxt = (rd_st != SL_SENT);
        end
        state_nxt = S_RESULT;
      end

      S_RESULT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // slot state, counters and targets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_st_r[i]    <= SL_FREE;
        sends_done_r[i] <= '0;
        sends_want_r[i] <= REPEAT_W'(1);
      end
    end else begin
      if (wr_st_en) begin
        slot_st_r[ptr_r] <= wr_st_val;
      end
      if (wr_done_en) begin
        sends_done_r[ptr_r] <= wr_done_val;
      end
      if (wr_want_en) begin
        sends_want_r[ptr_r] <= wr_want_val;
      end
    end
  end

  // recorded lengths, valid once queued
  always_ff @(posedge clk) begin
    if (wr_len_en) begin
      slot_len_r[ptr_r] <= len_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_chosen_slot   = out_slot_r;
  assign out_chosen_length = out_len_r;
  assign out_became_sent   = out_sent_r;

  // checks
  `PSP_ASSERT_NOW(a_sent_only_ok, out_valid && out_became_sent, out_status == RSP_OK,
    "became_sent reported on a failed transaction")
  `PSP_ASSERT_NOW(a_status_code, out_valid,
    out_status == RSP_OK || out_status == RSP_NONE || out_status == RSP_BAD_IDX,
    "undefined status code on output")
  `PSP_ASSERT_NEXT(a_count_marks_sent, state_r == S_COUNT && cnt_hit,
    slot_st_r[$past(ptr_r)] == SL_SENT, "slot not marked sent after reaching its target")
  `PSP_ASSERT_NEXT(a_result_lands, out_load, out_valid_r && state_r == S_IDLE,
    "result not loaded into the output register")

endmodule

`default_nettype wire
